// File: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; clk and rst are taken from the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/sle_pkg.sv
// shared types and constants for the sequential list engine
// no dependencies
package sle_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int MODE_W      = 2;
  localparam int POS_W       = 7;
  localparam int VALUE_W     = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic ld_idx_up;
    logic ld_idx_dn;
    logic ld_idx_zero;
    logic idx_dec;
    logic idx_inc;
    logic rd_en;
    logic mv_en;
    logic mv_up;
    logic cmp_en;
    logic place;
    logic cnt_inc;
    logic cnt_dec;
    logic set_ok;
    logic capture;
    logic load_out;
  } sle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic ins_ok;
    logic ins_move;
    logic del_ok;
    logic del_move;
    logic cnt_zero;
    logic idx_at_low;
    logic idx_at_top;
    logic match;
    logic out_free;
  } sle_status_t;

endpackage

// File: hdl/sle_ctrl.sv
// controller state machine of the sequential list engine
// depends on sle_pkg for the mode codes and the command and status types
module sle_ctrl import sle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sle_status_t status,
  output sle_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_UP       = 4'd2;
  localparam logic [3:0] S_DN       = 4'd3;
  localparam logic [3:0] S_DRAIN    = 4'd4;
  localparam logic [3:0] S_PLACE    = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_SCAN_END = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.mode)
          MODE_INSERT: begin
            if (!status.ins_ok) begin
              state_next = S_DONE;
            end else if (status.ins_move) begin
              cmd.ld_idx_up = 1'b1;
              state_next    = S_UP;
            end else begin
              state_next = S_PLACE;
            end
          end
          MODE_DELETE: begin
            if (!status.del_ok) begin
              state_next = S_DONE;
            end else if (status.del_move) begin
              cmd.ld_idx_dn = 1'b1;
              state_next    = S_DN;
            end else begin
              cmd.cnt_dec = 1'b1;
              cmd.set_ok  = 1'b1;
              state_next  = S_DONE;
            end
          end
          MODE_LOCATE: begin
            if (status.cnt_zero) begin
              state_next = S_DONE;
            end else begin
              cmd.ld_idx_zero = 1'b1;
              state_next      = S_SCAN;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      // move entries up one place, highest first
      S_UP: begin
        cmd.rd_en = 1'b1;
        cmd.mv_en = 1'b1;
        cmd.mv_up = 1'b1;
        if (status.idx_at_low) begin
          state_next = S_DRAIN;
        end else begin
          cmd.idx_dec = 1'b1;
        end
      end
      // move entries down one place, lowest first
      S_DN: begin
        cmd.rd_en = 1'b1;
        cmd.mv_en = 1'b1;
        if (status.idx_at_top) begin
          state_next = S_DRAIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // last move lands this cycle
      S_DRAIN: begin
        if (status.mode == MODE_INSERT) begin
          state_next = S_PLACE;
        end else begin
          cmd.cnt_dec = 1'b1;
          cmd.set_ok  = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_PLACE: begin
        cmd.place   = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.set_ok  = 1'b1;
        state_next  = S_DONE;
      end
      S_SCAN: begin
        if (status.match) begin
          cmd.capture = 1'b1;
          cmd.set_ok  = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.cmp_en = 1'b1;
          if (status.idx_at_top) begin
            state_next = S_SCAN_END;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_SCAN_END: begin
        if (status.match) begin
          cmd.capture = 1'b1;
          cmd.set_ok  = 1'b1;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/sle_datapath.sv
// datapath of the sequential list engine: entry store, count, index and result register
// depends on sle_pkg for field widths, mode codes and the command and status types
module sle_datapath import sle_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  sle_cmd_t               cmd,
  output sle_status_t            status,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [MODE_W-1:0]         mode_r;
  logic [POS_W-1:0]          pos_r;
  logic signed [VALUE_W-1:0] val_r;

  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [VALUE_W-1:0] rd_data;
  logic               mv_valid;
  logic [AW-1:0]      mv_dst;
  logic               cmp_valid;
  logic [CW-1:0]      cmp_idx;
  logic [CW-1:0]      found;
  logic               ok;

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] idx_x;
  logic [CMPW-1:0] pos_m1;
  logic [CMPW-1:0] cnt_m1;
  logic [CW-1:0]   idx_up1;
  logic [CW-1:0]   idx_dn1;

  assign pos_x   = CMPW'(pos_r);
  assign cnt_x   = CMPW'(count);
  assign idx_x   = CMPW'(idx);
  assign pos_m1  = pos_x - CMPW'(1);
  assign cnt_m1  = cnt_x - CMPW'(1);
  assign idx_up1 = idx + CW'(1);
  assign idx_dn1 = idx - CW'(1);

  always_comb begin
    status.mode       = mode_r;
    status.ins_ok     = (pos_r != '0) && (pos_x <= cnt_x + CMPW'(1)) &&
                        (cnt_x < CMPW'(DEPTH));
    status.ins_move   = (cnt_x >= pos_x);
    status.del_ok     = (pos_r != '0) && (pos_x <= cnt_x);
    status.del_move   = (pos_x < cnt_x);
    status.cnt_zero   = (count == '0);
    status.idx_at_low = (idx_x == pos_m1);
    status.idx_at_top = (idx_x == cnt_m1);
    status.match      = cmp_valid && (rd_data == val_r);
    status.out_free   = !out_valid || out_ready;
  end

  // request fields, tdata holds mode, position, value from bit 0 up
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_data[MODE_W-1:0];
      pos_r  <= in_data[MODE_W+POS_W-1:MODE_W];
      val_r  <= in_data[MODE_W+POS_W+VALUE_W-1:MODE_W+POS_W];
    end
  end

  // entry store: one read and one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[idx[AW-1:0]];
    end
    if (mv_valid) begin
      mem[mv_dst] <= rd_data;
    end else if (cmd.place) begin
      mem[pos_m1[AW-1:0]] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_idx_up) begin
      idx <= count - CW'(1);
    end else if (cmd.ld_idx_dn) begin
      idx <= CW'(pos_r);
    end else if (cmd.ld_idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_dec) begin
      idx <= idx_dn1;
    end else if (cmd.idx_inc) begin
      idx <= idx_up1;
    end
    // destination of the entry read this cycle
    mv_dst  <= cmd.mv_up ? idx_up1[AW-1:0] : idx_dn1[AW-1:0];
    cmp_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      mv_valid  <= 1'b0;
      cmp_valid <= 1'b0;
      ok        <= 1'b0;
      found     <= '0;
      out_valid <= 1'b0;
      out_data  <= '0;
    end else begin
      mv_valid  <= cmd.mv_en;
      cmp_valid <= cmd.cmp_en;
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.accept) begin
        ok    <= 1'b0;
        found <= '0;
      end else begin
        if (cmd.set_ok) begin
          ok <= 1'b1;
        end
        if (cmd.capture) begin
          found <= cmp_idx + CW'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        out_data  <= {1'b0, POS_W'(count), POS_W'(found), ok};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/sequential_list_engine.sv
// sequential list engine: one request at a time on a single-port-pair entry store
// steps: accept, decode, then the store moves or reads one entry per cycle for each
// moved or scanned entry, then the request finishes and its result is loaded once the
// output register is free. a new request is taken while the last result waits.
// reset clears the entry count and the handshake state; the store is not cleared
`include "assert_macros.svh"
module sequential_list_engine import sle_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // mode [1:0], position [8:2], value [40:9], zero above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // success [0], found_position [7:1], list_length [14:8], zero above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  sle_cmd_t    cmd;
  sle_status_t status;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sle_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

  `ASSERT_CLK(a_busy_after_req, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "request taken while busy")
  `ASSERT_CLK(a_no_write_clash, cmd.place |-> !$past(cmd.mv_en), "place collides with a pending move")
  `ASSERT_CLK(a_load_when_free, cmd.load_out |-> (!m_axis_tvalid || m_axis_tready), "result overwritten before taken")
  `ASSERT_CLK(a_found_is_success, (m_axis_tvalid && (m_axis_tdata[7:1] != 7'd0)) |-> m_axis_tdata[0], "position given without success")
  `ASSERT_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid, "result valid after reset")

endmodule

// File: dv/sequential_list_engine_tb.sv
// self-checking testbench for sequential_list_engine: directed table, then random insert,
// delete, locate and unused-mode requests checked against an in-bench list predictor
// depends on sle_pkg and the sequential_list_engine rtl
module sequential_list_engine_tb;
  import sle_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_PER_PHASE = 650;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 8;

  typedef struct packed {
    logic [IN_TDATA_W-MODE_W-POS_W-VALUE_W-1:0] pad;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic [MODE_W-1:0]  mode;
  } list_req_t;

  typedef struct packed {
    logic [OUT_TDATA_W-2*POS_W-2:0] pad;
    logic [POS_W-1:0] list_length;
    logic [POS_W-1:0] found_position;
    logic             success;
  } list_res_t;

  typedef struct {
    list_req_t req;
    bit        typed;
    list_res_t res;
  } directed_row_t;

  typedef enum {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [VALUE_W-1:0] shadow_list[$];
  list_res_t pending_results[$];
  int mismatch_count = 0;
  int snd_idle_pct = 31;
  int rcv_idle_pct = 65;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  always #1 clk = ~clk;

  sequential_list_engine #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // applies one request to the shadow list and returns the result it produces
  function automatic list_res_t predict_list_op(list_req_t r);
    list_res_t res;
    int k;
    int count;
    res = '0;
    k = 0;
    count = shadow_list.size();
    case (r.mode)
      MODE_INSERT: begin
        if (r.position >= 1 && r.position <= count + 1 && count < LIST_DEPTH) begin
          shadow_list.insert(int'(r.position) - 1, r.value);
          res.success = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (r.position >= 1 && r.position <= count) begin
          shadow_list.delete(int'(r.position) - 1);
          res.success = 1'b1;
        end
      end
      MODE_LOCATE: begin
        while (k < count && shadow_list[k] != r.value) k++;
        if (k < count) begin
          res.success = 1'b1;
          res.found_position = POS_W'(k + 1);
        end
      end
      default: ;
    endcase
    res.list_length = POS_W'(shadow_list.size());
    return res;
  endfunction

  function automatic directed_row_t dir_row(logic [MODE_W-1:0] m, int unsigned p,
                                            logic [VALUE_W-1:0] v, bit typed,
                                            bit s = 1'b0, int unsigned f = 0,
                                            int unsigned l = 0);
    directed_row_t row;
    row.req = '0;
    row.req.mode = m;
    row.req.position = POS_W'(p);
    row.req.value = v;
    row.typed = typed;
    row.res = '0;
    row.res.success = s;
    row.res.found_position = POS_W'(f);
    row.res.list_length = POS_W'(l);
    return row;
  endfunction

  // small values give duplicates so that first-match order gets exercised
  function automatic logic [VALUE_W-1:0] random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return VALUE_W'($urandom_range(7));
    if (pick < 50) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic list_req_t next_random_req(trend_t trend);
    list_req_t r;
    int pick;
    int ins_lim;
    int del_lim;
    int count;
    r = '0;
    count = shadow_list.size();
    case (trend)
      TREND_GROW:   begin ins_lim = 80; del_lim = 90; end
      TREND_SHRINK: begin ins_lim = 15; del_lim = 85; end
      default:      begin ins_lim = 40; del_lim = 70; end
    endcase
    pick = $urandom_range(99);
    if (pick < ins_lim) r.mode = MODE_INSERT;
    else if (pick < del_lim) r.mode = MODE_DELETE;
    else if (pick < 98) r.mode = MODE_LOCATE;
    else r.mode = MODE_UNUSED;
    r.value = random_value();
    case (r.mode)
      MODE_INSERT: begin
        if ($urandom_range(99) < 88) r.position = POS_W'($urandom_range(count + 1, 1));
        else if ($urandom_range(1)) r.position = '0;
        else r.position = POS_W'($urandom_range(127, count + 2));
      end
      MODE_DELETE: begin
        if (count > 0 && $urandom_range(99) < 88)
          r.position = POS_W'($urandom_range(count, 1));
        else if ($urandom_range(1)) r.position = '0;
        else r.position = POS_W'($urandom_range(127, count + 1));
      end
      default: begin
        r.position = POS_W'($urandom_range(127));
        if (r.mode == MODE_LOCATE && count > 0 && $urandom_range(99) < 65)
          r.value = shadow_list[$urandom_range(count - 1)];
      end
    endcase
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(list_req_t r, bit typed, list_res_t typed_res);
    list_res_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= r;
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_list_op(r);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    list_res_t got;
    list_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h with no request pending", $time, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.success !== want.success) begin
          $display("%0t: success expected %0d got %0d", $time, want.success, got.success);
          mismatch_count++;
        end
        if (got.found_position !== want.found_position) begin
          $display("%0t: found_position expected %0d got %0d", $time,
                   want.found_position, got.found_position);
          mismatch_count++;
        end
        if (got.list_length !== want.list_length) begin
          $display("%0t: list_length expected %0d got %0d", $time,
                   want.list_length, got.list_length);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    directed_row_t directed_rows[$];
    trend_t trend;
    int run_left;
    list_req_t r;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list, bad positions, extremes, first match among duplicates
    directed_rows.push_back(dir_row(MODE_LOCATE, 0, 32'd5, 1, 0, 0, 0));
    directed_rows.push_back(dir_row(MODE_DELETE, 1, 32'd0, 1, 0, 0, 0));
    directed_rows.push_back(dir_row(MODE_INSERT, 0, 32'd1, 1, 0, 0, 0));
    directed_rows.push_back(dir_row(MODE_INSERT, 2, 32'd1, 1, 0, 0, 0));
    directed_rows.push_back(dir_row(MODE_INSERT, 1, 32'h8000_0000, 1, 1, 0, 1));
    directed_rows.push_back(dir_row(MODE_INSERT, 2, 32'h7fff_ffff, 1, 1, 0, 2));
    directed_rows.push_back(dir_row(MODE_INSERT, 1, 32'h0000_0000, 1, 1, 0, 3));
    directed_rows.push_back(dir_row(MODE_LOCATE, 0, 32'h7fff_ffff, 1, 1, 3, 3));
    directed_rows.push_back(dir_row(MODE_LOCATE, 127, 32'h8000_0000, 1, 1, 2, 3));
    directed_rows.push_back(dir_row(MODE_UNUSED, 127, 32'hffff_ffff, 1, 0, 0, 3));
    directed_rows.push_back(dir_row(MODE_INSERT, 127, 32'hffff_ffff, 1, 0, 0, 3));
    directed_rows.push_back(dir_row(MODE_DELETE, 127, 32'd0, 1, 0, 0, 3));
    directed_rows.push_back(dir_row(MODE_DELETE, 4, 32'd0, 1, 0, 0, 3));
    directed_rows.push_back(dir_row(MODE_DELETE, 0, 32'd0, 1, 0, 0, 3));
    directed_rows.push_back(dir_row(MODE_INSERT, 4, 32'hffff_ffff, 1, 1, 0, 4));
    directed_rows.push_back(dir_row(MODE_INSERT, 2, 32'hffff_ffff, 0));
    directed_rows.push_back(dir_row(MODE_LOCATE, 0, 32'hffff_ffff, 0));
    directed_rows.push_back(dir_row(MODE_DELETE, 1, 32'd0, 0));
    directed_rows.push_back(dir_row(MODE_LOCATE, 0, 32'd0, 0));
    directed_rows.push_back(dir_row(MODE_DELETE, 4, 32'd0, 0));
    directed_rows.push_back(dir_row(MODE_INSERT, 5, 32'd1, 0));
    directed_rows.push_back(dir_row(MODE_LOCATE, 0, 32'h7fff_ffff, 0));

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    drain_results();

    // start by growing so the list reaches full early on
    trend = TREND_GROW;
    run_left = 120;
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 65 : 0;
      rcv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 31 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (run_left == 0) begin
          trend = trend_t'($urandom_range(2));
          run_left = $urandom_range(160, 40);
        end
        run_left--;
        if (ph == 0 && n == RANDOM_PER_PHASE / 2) hold_request <= 1'b1;
        r = next_random_req(trend);
        send_request(r, 1'b0, '0);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
